// ----- hdl/rv32im_integer_execute_assert.svh -----
// Assertion macros used by the port checker.
`ifndef RV32IM_INTEGER_EXECUTE_ASSERT_SVH
`define RV32IM_INTEGER_EXECUTE_ASSERT_SVH
// Implication checked every clock outside reset.
`define RVX_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked every clock outside reset.
`define RVX_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ----- hdl/rvx_pkg.sv -----
// ----------------------------------------------------------------------------
// RV32IM execute package
// Opcodes, status codes and shared types of the execute block.
// ----------------------------------------------------------------------------
package rvx_pkg;
   localparam int NumRegs = 32;
   localparam int RegIdxW = $clog2(NumRegs);

   localparam logic [6:0] OpcOpImm  = 7'h13;
   localparam logic [6:0] OpcOp     = 7'h33;
   localparam logic [6:0] OpcLui    = 7'h37;
   localparam logic [6:0] OpcAuipc  = 7'h17;
   localparam logic [6:0] OpcJal    = 7'h6f;
   localparam logic [6:0] OpcJalr   = 7'h67;
   localparam logic [6:0] OpcBranch = 7'h63;

   localparam logic [1:0] StatusOk      = 2'd0;
   localparam logic [1:0] StatusIllegal = 2'd1;
   localparam logic [1:0] StatusUnknown = 2'd2;

   // Operations of the shared multiply/divide unit.
   typedef enum logic [1:0] {MdMul, MdDiv} md_op_type;

   typedef struct packed {
      logic        start;
      md_op_type   op;
      logic [2:0]  funct3;
      logic [31:0] a;
      logic [31:0] b;
   } md_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] result;
   } md_rsp_type;
endpackage

// ----- hdl/rvx_req_if.sv -----
// ----------------------------------------------------------------------------
// Instruction channel
// Valid/ready channel carrying one instruction word per transaction.
// ----------------------------------------------------------------------------
interface rvx_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] instr_word;
   modport source (output valid, output instr_word, input ready);
   modport sink (input valid, input instr_word, output ready);
endinterface

// ----- hdl/rvx_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one execution result per transaction.
// ----------------------------------------------------------------------------
interface rvx_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] next_pc;
   logic [4:0]  dest_index;
   logic [31:0] dest_value;
   logic        dest_written;
   logic        took_branch;
   logic [1:0]  status;
   modport source (output valid, output next_pc, output dest_index, output dest_value,
                   output dest_written, output took_branch, output status, input ready);
   modport sink (input valid, input next_pc, input dest_index, input dest_value,
                 input dest_written, input took_branch, input status, output ready);
endinterface

// ----- hdl/rvx_muldiv.sv -----
// ----------------------------------------------------------------------------
// Iterative multiply/divide unit
// Shift-add multiplier and restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
module rvx_muldiv import rvx_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  md_req_type md_req,
   output md_rsp_type md_rsp
);
   typedef enum logic [1:0] {Idle, Run, Fin} state_type;
   state_type   state_ff;
   md_op_type   op_ff;
   logic [2:0]  f3_ff;
   logic [5:0]  cnt_ff;
   logic [65:0] acc_ff;      // product, or remainder:quotient
   logic [32:0] mcand_ff;    // multiplicand (33-bit signed) or divisor magnitude
   logic [32:0] mplier_ff;   // multiplier bits shifted out at the bottom
   logic        nq_ff, nr_ff, zero_ff, ovf_ff;
   logic [31:0] a_ff, res_ff;
   logic        done_ff;

   logic        sa, sb;
   logic [32:0] ea, eb;
   logic [32:0] trial;
   logic [63:0] sh;
   logic [66:0] padd;

   always_comb begin
      sa = md_req.a[31] & (md_req.funct3 == 3'd1 || md_req.funct3 == 3'd2
                           || md_req.funct3 == 3'd4 || md_req.funct3 == 3'd6);
      sb = md_req.b[31] & (md_req.funct3 == 3'd1 || md_req.funct3 == 3'd4
                           || md_req.funct3 == 3'd6);
      ea = {sa, md_req.a};
      eb = {sb, md_req.b};
      sh = {acc_ff[62:0], 1'b0};
      // The partial remainder can reach 33 bits once shifted.
      trial = {acc_ff[63], sh[63:32]} - mcand_ff;
      // Signed add of the multiplicand; the top multiplier bit has negative weight.
      if (mplier_ff[0]) begin
         if (cnt_ff == 6'd32) padd = {acc_ff[65], acc_ff}
                                     - {mcand_ff[32], mcand_ff, 33'd0};
         else padd = {acc_ff[65], acc_ff} + {mcand_ff[32], mcand_ff, 33'd0};
      end else begin
         padd = {acc_ff[65], acc_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= Idle;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            Idle: if (md_req.start) begin
               op_ff   <= md_req.op;
               f3_ff   <= md_req.funct3;
               a_ff    <= md_req.a;
               cnt_ff  <= 6'd0;
               zero_ff <= (md_req.b == 32'd0);
               ovf_ff  <= sa && sb && md_req.a == 32'h8000_0000 && md_req.b == 32'hffff_ffff;
               nq_ff   <= sa ^ sb;
               nr_ff   <= sa;
               if (md_req.op == MdMul) begin
                  acc_ff    <= 66'd0;
                  mcand_ff  <= ea;
                  mplier_ff <= eb;
               end else begin
                  acc_ff    <= {34'd0, sa ? (32'd0 - md_req.a) : md_req.a};
                  mcand_ff  <= {1'b0, sb ? (32'd0 - md_req.b) : md_req.b};
                  mplier_ff <= 33'd0;
               end
               state_ff <= Run;
            end
            Run: begin
               if (op_ff == MdMul) begin
                  // Accumulate in the top half, shift right one each step.
                  acc_ff    <= padd[66:1];
                  mplier_ff <= {1'b0, mplier_ff[32:1]};
                  if (cnt_ff == 6'd32) state_ff <= Fin;
               end else begin
                  if (!trial[32]) acc_ff <= {2'b00, trial[31:0], sh[31:1], 1'b1};
                  else acc_ff <= {2'b00, sh};
                  if (cnt_ff == 6'd31) state_ff <= Fin;
               end
               cnt_ff <= cnt_ff + 6'd1;
            end
            Fin: begin
               if (op_ff == MdMul) begin
                  res_ff <= (f3_ff == 3'd0) ? acc_ff[31:0] : acc_ff[63:32];
               end else if (f3_ff[1] == 1'b0) begin
                  if (zero_ff) res_ff <= 32'hffff_ffff;
                  else if (ovf_ff) res_ff <= a_ff;
                  else res_ff <= nq_ff ? (32'd0 - acc_ff[31:0]) : acc_ff[31:0];
               end else begin
                  if (zero_ff) res_ff <= a_ff;
                  else if (ovf_ff) res_ff <= 32'd0;
                  else res_ff <= nr_ff ? (32'd0 - acc_ff[63:32]) : acc_ff[63:32];
               end
               done_ff  <= 1'b1;
               state_ff <= Idle;
            end
            default: state_ff <= Idle;
         endcase
      end
   end

   assign md_rsp.done   = done_ff;
   assign md_rsp.result = res_ff;
endmodule

// ----- hdl/rv32im_integer_execute.sv -----
// A base instruction passes from the Exec state to Resp; a multiply or divide
// also waits in Md for the iterative unit, which works one bit per cycle.
// One instruction is in flight at a time; the next is taken the cycle after the
// result is taken.
// Reset clears the program counter to zero and all register valid bits;
// the register file reads zero until written, held by per-entry valid bits.
// ----------------------------------------------------------------------------
// RV32IM integer execute
// Holds register file and pc, executes one instruction per transaction.
// ----------------------------------------------------------------------------
module rv32im_integer_execute import rvx_pkg::*; (
   input logic         clock,
   input logic         reset,
   rvx_req_if.sink     req,
   rvx_rsp_if.source   rsp
);
   typedef enum logic [1:0] {Idle, Exec, Md, Resp} state_type;
   state_type   state_ff;
   logic [31:0] ins_ff, pc_ff;
   logic [31:0] rf_ff [NumRegs];
   logic [NumRegs-1:0] vld_ff;
   logic [31:0] npc_ff, val_ff;
   logic [4:0]  di_ff;
   logic        wr_ff, tb_ff;
   logic [1:0]  st_ff;
   md_req_type  md_req;
   md_rsp_type  md_rsp;

   logic [6:0]  opc;
   logic [4:0]  rd, rs1, rs2;
   logic [2:0]  f3;
   logic [6:0]  f7;
   logic [31:0] a, b, immi, immb, immj, opb, val, npc, pc4;
   logic        wr, tb, ill, unk, rd_bad, rs1_bad, rs2_bad, lt, ltu, is_md;
   logic [4:0]  shamt;

   function automatic logic [31:0] rd_reg(input logic [4:0] idx,
                                          input logic [NumRegs-1:0] v,
                                          input logic [31:0] r);
      logic [31:0] res;
      res = 32'd0;
      if (idx != 5'd0 && 32'(idx) < NumRegs && v[idx[RegIdxW-1:0]]) res = r;
      return res;
   endfunction

   always_comb begin
      opc = ins_ff[6:0];
      rd  = ins_ff[11:7];
      f3  = ins_ff[14:12];
      rs1 = ins_ff[19:15];
      rs2 = ins_ff[24:20];
      f7  = ins_ff[31:25];
      a = rd_reg(rs1, vld_ff, rf_ff[rs1[RegIdxW-1:0]]);
      b = rd_reg(rs2, vld_ff, rf_ff[rs2[RegIdxW-1:0]]);
      rd_bad  = 32'(rd) >= NumRegs;
      rs1_bad = 32'(rs1) >= NumRegs;
      rs2_bad = 32'(rs2) >= NumRegs;
      immi = {{20{ins_ff[31]}}, ins_ff[31:20]};
      immb = {{20{ins_ff[31]}}, ins_ff[7], ins_ff[30:25], ins_ff[11:8], 1'b0};
      immj = {{12{ins_ff[31]}}, ins_ff[19:12], ins_ff[20], ins_ff[30:21], 1'b0};
      pc4 = pc_ff + 32'd4;
      opb = (opc == OpcOp) ? b : immi;
      shamt = (opc == OpcOp) ? b[4:0] : rs2;
      lt  = $signed(a) < $signed(opb);
      ltu = a < opb;
      npc = pc4; val = 32'd0; wr = 1'b0; tb = 1'b0; ill = 1'b0; unk = 1'b0;
      is_md = 1'b0;
      case (opc)
         OpcOpImm, OpcOp: begin
            if (rd_bad || rs1_bad || (opc == OpcOp && rs2_bad)) ill = 1'b1;
            else if (opc == OpcOp && f7 == 7'd1) begin
               wr = 1'b1; is_md = 1'b1;
            end else begin
               wr = 1'b1;
               if (opc == OpcOp && f7 != 7'd0 && !(f7 == 7'h20 && (f3 == 3'd0 || f3 == 3'd5)))
                  ill = 1'b1;
               if (opc == OpcOpImm && f3 == 3'd1 && f7 != 7'd0) ill = 1'b1;
               if (opc == OpcOpImm && f3 == 3'd5 && f7 != 7'd0 && f7 != 7'h20) ill = 1'b1;
               case (f3)
                  3'd0: val = (opc == OpcOp && f7[5]) ? a - opb : a + opb;
                  3'd1: val = a << shamt;
                  3'd2: val = {31'd0, lt};
                  3'd3: val = {31'd0, ltu};
                  3'd4: val = a ^ opb;
                  3'd5: val = f7[5] ? 32'($signed(a) >>> shamt) : a >> shamt;
                  3'd6: val = a | opb;
                  default: val = a & opb;
               endcase
            end
         end
         OpcLui: begin
            ill = rd_bad; wr = 1'b1; val = {ins_ff[31:12], 12'd0};
         end
         OpcAuipc: begin
            ill = rd_bad; wr = 1'b1; val = pc_ff + {ins_ff[31:12], 12'd0};
         end
         OpcJal: begin
            ill = rd_bad; wr = 1'b1; val = pc4; tb = 1'b1; npc = pc_ff + immj;
         end
         OpcJalr: begin
            ill = f3 != 3'd0 || rd_bad || rs1_bad;
            wr = 1'b1; val = pc4; tb = 1'b1;
            npc = (a + immi) & ~32'd1;
         end
         OpcBranch: begin
            ill = f3 == 3'd2 || f3 == 3'd3 || rs1_bad || rs2_bad;
            case (f3)
               3'd0: tb = a == b;
               3'd1: tb = a != b;
               3'd4: tb = $signed(a) < $signed(b);
               3'd5: tb = !($signed(a) < $signed(b));
               3'd6: tb = a < b;
               default: tb = a >= b;
            endcase
            if (tb) npc = pc_ff + immb;
         end
         default: unk = 1'b1;
      endcase
      if (rd == 5'd0) wr = 1'b0;
      md_req.start  = (state_ff == Exec) && is_md && !ill;
      md_req.op     = f3[2] ? MdDiv : MdMul;
      md_req.funct3 = f3;
      md_req.a      = a;
      md_req.b      = b;
   end

   rvx_muldiv u_md (.clock(clock), .reset(reset), .md_req(md_req), .md_rsp(md_rsp));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= Idle;
         pc_ff    <= 32'd0;
         vld_ff   <= '0;
      end else begin
         case (state_ff)
            Idle: if (req.valid) begin
               ins_ff   <= req.instr_word;
               state_ff <= Exec;
            end
            Exec: begin
               if (ill || unk) begin
                  npc_ff <= pc_ff; di_ff <= 5'd0; val_ff <= 32'd0; wr_ff <= 1'b0;
                  tb_ff <= 1'b0; st_ff <= unk ? StatusUnknown : StatusIllegal;
                  state_ff <= Resp;
               end else begin
                  npc_ff <= npc; pc_ff <= npc; st_ff <= StatusOk;
                  di_ff <= wr ? rd : 5'd0; wr_ff <= wr; tb_ff <= tb;
                  val_ff <= wr ? val : 32'd0;
                  if (is_md) state_ff <= Md;
                  else begin
                     if (wr) begin
                        rf_ff[rd[RegIdxW-1:0]] <= val;
                        vld_ff[rd[RegIdxW-1:0]] <= 1'b1;
                     end
                     state_ff <= Resp;
                  end
               end
            end
            Md: if (md_rsp.done) begin
               if (wr_ff) begin
                  rf_ff[di_ff[RegIdxW-1:0]]  <= md_rsp.result;
                  vld_ff[di_ff[RegIdxW-1:0]] <= 1'b1;
                  val_ff <= md_rsp.result;
               end
               state_ff <= Resp;
            end
            Resp: if (rsp.ready) state_ff <= Idle;
            default: state_ff <= Idle;
         endcase
      end
   end

   assign req.ready        = state_ff == Idle;
   assign rsp.valid        = state_ff == Resp;
   assign rsp.next_pc      = npc_ff;
   assign rsp.dest_index   = di_ff;
   assign rsp.dest_value   = val_ff;
   assign rsp.dest_written = wr_ff;
   assign rsp.took_branch  = tb_ff;
   assign rsp.status       = st_ff;
endmodule

// ----- hdl/rvx_checker.sv -----
// ----------------------------------------------------------------------------
// Port checker
// Watches the top-level channels of the execute block.
// ----------------------------------------------------------------------------
`include "rv32im_integer_execute_assert.svh"
module rvx_checker import rvx_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [4:0]  rsp_dest_index,
   input logic        rsp_dest_written,
   input logic [1:0]  rsp_status
);
   `RVX_ASSERT_IMP(a_no_overlap, clock, reset, rsp_valid, !req_ready)
   `RVX_ASSERT_IMP(a_x0_never, clock, reset, rsp_valid && rsp_dest_written,
                   rsp_dest_index != 5'd0)
   `RVX_ASSERT_IMP(a_bad_no_write, clock, reset, rsp_valid && rsp_status != StatusOk,
                   !rsp_dest_written)
   `RVX_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `RVX_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
endmodule

bind rv32im_integer_execute rvx_checker u_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_dest_index(rsp.dest_index),
   .rsp_dest_written(rsp.dest_written), .rsp_status(rsp.status));
